// ===== rtl/tfdis_pkg.sv =====
// package: operation codes, status codes, controller states and command/status structs
package tfdis_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_DISPATCH = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_TICK     = 3'd3,
    OP_PREV     = 3'd4,
    OP_NEXT     = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic [0:0] REG_SYNC_DL  = 1'b0;
  localparam logic [0:0] REG_ASYNC_DL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_NEIGH,
    S_SHIFT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic exec;       // ops done without a search: add, tick, dispatch select
    logic scan_start; // reset search index
    logic scan_step;  // advance search index
    logic nb_read;    // read neighbour entry
    logic shift_step; // move one entry down
    logic shift_end;  // decrement count
    logic fill_out;   // register the result word
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       scan_end;
    logic       shift_last;
    logic       need_shift; // dispatch found a source
  } dp_stat_t;

endpackage

// ===== rtl/tfdis_if.sv =====
// valid/ready channel interface
interface tfdis_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tfdis_ctrl.sv =====
// controller state machine sequencing search, neighbour read and compaction
module tfdis_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tfdis_pkg::dp_cmd_t cmd,
  input  tfdis_pkg::dp_stat_t stat
);
  import tfdis_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.op == OP_ADD || stat.op == OP_TICK || stat.op > OP_NEXT) begin
          cmd.exec = 1'b1;
          cmd.fill_out = 1'b1;
          state_next = S_DONE;
        end else if (stat.op == OP_DISPATCH) begin
          cmd.exec = 1'b1;
          if (stat.need_shift) begin
            state_next = S_SHIFT;
          end else begin
            cmd.fill_out = 1'b1;
            state_next = S_DONE;
          end
        end else if (stat.hit) begin
          if (stat.op == OP_REMOVE) state_next = S_SHIFT;
          else state_next = S_NEIGH;
        end else if (stat.scan_end) begin
          cmd.fill_out = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_NEIGH: begin
        cmd.nb_read = 1'b1;
        cmd.fill_out = 1'b1;
        state_next = S_DONE;
      end
      S_SHIFT: begin
        if (stat.shift_last) begin
          cmd.shift_end = 1'b1;
          cmd.fill_out = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_DONE)) else $error("result outside done");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

// ===== rtl/tfdis_dp.sv =====
// datapath: two queues, time counter, deadline registers, search and shift
module tfdis_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TICKS_PER_SECOND = 100
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [2:0]          in_op,
  input  logic [7:0]          in_tag,
  input  logic                in_sync,
  input  tfdis_pkg::dp_cmd_t  cmd,
  output tfdis_pkg::dp_stat_t stat,
  output logic                found,
  output logic [7:0]          result_tag,
  output logic                result_sync,
  output logic                queues_empty,
  output logic [1:0]          status
);
  import tfdis_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  // queue storage, index 1 = sync, 0 = async
  logic [7:0]  tags [2][QUEUE_DEPTH];
  logic [31:0] dls  [2][QUEUE_DEPTH];
  logic [CW-1:0] cnt [2];
  logic [31:0] now;
  logic [15:0] sync_dl, async_dl;

  // captured word and working registers
  logic [2:0] op;
  logic [7:0] tag;
  logic       cls;
  logic [CW-1:0] idx;
  logic          hit;
  logic [CW-1:0] pos;

  logic [AW-1:0] ia, ia1, pa;
  assign ia  = idx[AW-1:0];
  assign ia1 = AW'(idx + 1'b1);

  // head expiry and dispatch choice
  logic [31:0] sd, ad;
  logic se, ae, dsrc_ok, dsrc;
  always_comb begin
    sd = dls[1][0] - now;
    ad = dls[0][0] - now;
    se = (cnt[1] != '0) && sd[31];
    ae = (cnt[0] != '0) && ad[31];
    dsrc_ok = (cnt[0] != '0) || (cnt[1] != '0);
    if (ae) dsrc = 1'b0;
    else if (se) dsrc = 1'b1;
    else if (cnt[1] != '0) dsrc = 1'b1;
    else dsrc = 1'b0;
  end

  logic cur_hit;
  assign cur_hit = (idx < cnt[cls]) && (tags[cls][ia] == tag);

  assign stat.op = op;
  assign stat.hit = cur_hit;
  assign stat.scan_end = (idx + 1'b1 >= cnt[cls]);
  assign stat.shift_last = (idx + 1'b1 >= cnt[cls]);
  assign stat.need_shift = dsrc_ok;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt[0] <= '0;
      cnt[1] <= '0;
      now <= '0;
      sync_dl <= 16'(TICKS_PER_SECOND / 2);
      async_dl <= 16'(5 * TICKS_PER_SECOND);
      hit <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SYNC_DL) sync_dl <= cfg_data;
        else async_dl <= cfg_data;
      end
      if (cmd.load) hit <= 1'b0;
      if (cur_hit && !cmd.load) hit <= 1'b1;
      if (cmd.exec) begin
        if (op == OP_TICK) now <= now + 32'd1;
        if (op == OP_ADD && cnt[cls] < FULL) cnt[cls] <= cnt[cls] + 1'b1;
      end
      if (cmd.shift_end) cnt[cls] <= cnt[cls] - 1'b1;
    end
  end

  // working registers and storage writes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_op;
      tag <= in_tag;
      cls <= in_sync;
    end
    if (cmd.scan_start) idx <= '0;
    if (cmd.scan_step) idx <= idx + 1'b1;
    if (cur_hit) pos <= idx;
    if (cmd.exec && op == OP_ADD && cnt[cls] < FULL) begin
      tags[cls][cnt[cls][AW-1:0]] <= tag;
      dls[cls][cnt[cls][AW-1:0]] <= now + {16'd0, cls ? sync_dl : async_dl};
    end
    // keep the dispatched head before compaction overwrites it
    if (cmd.exec && op == OP_DISPATCH) begin
      cls <= dsrc;
      tag <= tags[dsrc][0];
      idx <= '0;
    end
    if (cmd.shift_step) begin
      tags[cls][ia] <= tags[cls][ia1];
      dls[cls][ia]  <= dls[cls][ia1];
      idx <= idx + 1'b1;
    end
  end

  // neighbour address
  always_comb begin
    pa = (op == OP_PREV) ? AW'(pos - 1'b1) : AW'(pos + 1'b1);
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.fill_out) begin
      found <= 1'b0;
      result_tag <= '0;
      result_sync <= 1'b0;
      status <= ST_OK;
      queues_empty <= (cnt[0] == '0) && (cnt[1] == '0);
      case (op)
        OP_ADD: begin
          if (cnt[cls] >= FULL) status <= ST_FULL;
          else queues_empty <= 1'b0;
        end
        OP_DISPATCH: begin
          if (dsrc_ok) begin
            found <= 1'b1;
            result_tag <= tag;
            result_sync <= cls;
            queues_empty <= ((cnt[cls] - 1'b1) == '0) && (cnt[!cls] == '0);
          end
        end
        OP_REMOVE: begin
          if (!hit) status <= ST_NOTFOUND;
          else queues_empty <= ((cnt[cls] - 1'b1) == '0) && (cnt[!cls] == '0);
        end
        OP_PREV, OP_NEXT: begin
          if (!hit) status <= ST_NOTFOUND;
          else if (cmd.nb_read && ((op == OP_PREV) ? (pos != '0)
                                   : (pos + 1'b1 < cnt[cls]))) begin
            found <= 1'b1;
            result_tag <= tags[cls][pa];
            result_sync <= cls;
          end
        end
        default: ;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt[0] <= FULL) && (cnt[1] <= FULL)) else $error("count overflow");
  a_tick: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op == OP_TICK) |=> (now == $past(now) + 32'd1)) else $error("tick");
  a_shift_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_end |-> (cnt[cls] != '0)) else $error("shift on empty queue");
endmodule

// ===== rtl/two_fifo_deadline_io_scheduler_top.sv =====
// top level: two-class deadline request scheduler
//
// Input channel "req" carries one word {operation, request_tag, is_sync};
// output channel "rsp" carries {found, result_tag, result_sync,
// queues_empty, status}. Every accepted request gives exactly one response.
// Configuration: cfg_we/cfg_index/cfg_data write sync_deadline (0) or
// async_deadline (1); higher indexes are ignored.
// One request is handled at a time. Add, tick and unused codes are
// executed without a search; dispatch compacts the chosen queue (no
// compaction when both are empty); a remove that hits searches and then
// compacts the queue; a remove or neighbour query that misses searches
// the whole queue; a neighbour query that hits searches, then reads the
// neighbour entry. The search and compaction walk one queue entry per
// cycle; the next request is taken in the cycle after the response word
// leaves, so no new request is accepted before the last one is through.
// Reset (rst, synchronous) empties both queues, zeroes time and loads
// the deadline registers with their defaults; no clearing pass is needed.
// When the receiver stalls, the response holds and no new request is taken.
module two_fifo_deadline_io_scheduler_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TICKS_PER_SECOND = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  tfdis_if.sink       req,
  tfdis_if.source     rsp
);
  import tfdis_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     found, result_sync, queues_empty;
  logic [7:0] result_tag;
  logic [1:0] status;
  logic       we_ok;

  // registers beyond index 1 are ignored
  assign we_ok = cfg_we && (cfg_index[7:1] == '0);

  tfdis_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .stat(stat)
  );

  tfdis_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .TICKS_PER_SECOND(TICKS_PER_SECOND)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(we_ok), .cfg_index(cfg_index[0:0]), .cfg_data(cfg_data),
    .in_op(req.data[11:9]), .in_tag(req.data[8:1]), .in_sync(req.data[0]),
    .cmd(cmd), .stat(stat),
    .found(found), .result_tag(result_tag), .result_sync(result_sync),
    .queues_empty(queues_empty), .status(status)
  );

  assign rsp.data = {found, result_tag, result_sync, queues_empty, status};
endmodule
